// ===== sv/ctcg_pkg.sv =====
// shared types, constants and the exp table of the ctc greedy decoder
package ctcg_pkg;

    localparam int SCORE_W     = 16;
    localparam int MASK_DEPTH  = 8192;
    localparam int MASK_AW     = 13;
    localparam int SIZE_W      = 14;
    localparam int CLASS_OUT_W = 13;
    localparam int CONF_W      = 16;
    localparam int PROB_W      = 17;
    localparam int EXP_DEPTH   = 1024;
    localparam int EXP_AW      = 10;
    localparam int DIV_DW      = 33;
    localparam logic [63:0] EXP_RATIO = 64'd4228380000;
    localparam logic signed [SCORE_W-1:0] PROB_LOWER = -16'sd1;
    localparam logic signed [SCORE_W-1:0] PROB_UPPER = 16'sd1025;

    // configuration register indexes
    localparam logic REG_MASK_ENABLE = 1'b0;
    localparam logic REG_MASK_SIZE   = 1'b1;

    // input action codes
    localparam logic ACT_SCORE = 1'b0;
    localparam logic ACT_MASK  = 1'b1;

    // result kind codes
    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_MEAN   = 1'b1;

    typedef logic [PROB_W-1:0] t_exp_tab [EXP_DEPTH];

    // exp(-k/64) in q1.16 built from a truncating q1.32 product chain
    function automatic t_exp_tab exp_gen();
        t_exp_tab    tab;
        logic [63:0] acc;
        acc = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            tab[k] = PROB_W'(acc >> 16);
            acc    = (acc * EXP_RATIO) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_gen();

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic clearing;
        logic scan;
        logic start2;
        logic bypass;
        logic div_prob;
        logic take_prob;
        logic update;
        logic load_sym;
        logic div_mean;
        logic load_mean;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic step_acc;
        logic scan_end;
        logic pipe_empty;
        logic bypass_ok;
        logic div_busy;
        logic sym_pend;
        logic seq_end;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/ctcg_ram.sv =====
// generic single write port, single read port ram with registered read
module ctcg_ram #(
    parameter int W = 16,
    parameter int D = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ctcg_div.sv =====
// restoring divider, one quotient bit per cycle
module ctcg_div #(
    parameter int DW = 33,
    parameter int VW = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;

    // shift in one dividend bit and try the subtraction
    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[VW]) begin
                r_rem <= w_diff[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== sv/ctcg_ctrl.sv =====
// sequencing state machine of the ctc greedy decoder
module ctcg_ctrl
    import ctcg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN1, S_DRAIN1, S_DECIDE, S_SCAN2, S_DRAIN2,
        S_DIVP, S_DIVPW, S_UPDATE, S_SYM, S_DIVM, S_DIVMW, S_MEAN
    } t_state;

    t_state r_state;

    // commands from state and status
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR:  o_cmd.clearing  = 1'b1;
            S_IDLE:   o_cmd.in_ready  = 1'b1;
            S_SCAN1:  o_cmd.scan      = 1'b1;
            S_SCAN2:  o_cmd.scan      = 1'b1;
            S_DECIDE: begin
                o_cmd.bypass = i_sts.bypass_ok;
                o_cmd.start2 = !i_sts.bypass_ok;
            end
            S_DIVP:   o_cmd.div_prob  = 1'b1;
            S_DIVPW:  o_cmd.take_prob = !i_sts.div_busy;
            S_UPDATE: o_cmd.update    = 1'b1;
            S_SYM:    o_cmd.load_sym  = i_sts.sym_pend && i_sts.out_free;
            S_DIVM:   o_cmd.div_mean  = 1'b1;
            S_MEAN:   o_cmd.load_mean = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR:  if (i_sts.clear_done) r_state <= S_IDLE;
                S_IDLE:   if (i_sts.step_acc) r_state <= S_SCAN1;
                S_SCAN1:  if (i_sts.scan_end) r_state <= S_DRAIN1;
                S_DRAIN1: if (i_sts.pipe_empty) r_state <= S_DECIDE;
                S_DECIDE: r_state <= i_sts.bypass_ok ? S_UPDATE : S_SCAN2;
                S_SCAN2:  if (i_sts.scan_end) r_state <= S_DRAIN2;
                S_DRAIN2: if (i_sts.pipe_empty) r_state <= S_DIVP;
                S_DIVP:   r_state <= S_DIVPW;
                S_DIVPW:  if (!i_sts.div_busy) r_state <= S_UPDATE;
                S_UPDATE: r_state <= S_SYM;
                S_SYM: begin
                    if (!i_sts.sym_pend || i_sts.out_free) begin
                        r_state <= i_sts.seq_end ? S_DIVM : S_IDLE;
                    end
                end
                S_DIVM:   r_state <= S_DIVMW;
                S_DIVMW:  if (!i_sts.div_busy) r_state <= S_MEAN;
                S_MEAN:   if (i_sts.out_free) r_state <= S_IDLE;
                default:  r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

// ===== sv/ctcg_dp.sv =====
// datapath: row and mask memories, scan pipeline, accumulators, divider, output register
module ctcg_dp
    import ctcg_pkg::*;
#(
    parameter int NUM_CLASSES = 8192,
    parameter int MAX_STEPS   = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [13:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int CIW  = $clog2(NUM_CLASSES);
    localparam int CNW  = $clog2(NUM_CLASSES + 1);
    localparam int SUMW = CNW + 16;
    localparam int SCW  = $clog2(MAX_STEPS + 1);
    localparam int PSW  = SCW + PROB_W;

    // input fields
    logic                      w_act;
    logic signed [SCORE_W-1:0] w_score;
    logic [MASK_AW-1:0]        w_maddr;
    logic                      w_mbit;
    logic                      w_acc;

    assign w_act   = i_s_tuser[0];
    assign w_score = i_s_tdata[15:0];
    assign w_maddr = i_s_tdata[28:16];
    assign w_mbit  = i_s_tdata[29];
    assign w_acc   = i_s_tvalid && i_cmd.in_ready;

    logic                      r_mask_en;
    logic [SIZE_W-1:0]         r_mask_size;
    logic [CNW-1:0]            r_cc;
    logic [CNW-1:0]            r_idx;
    logic                      r_rd_valid;
    logic [CIW-1:0]            r_rd_idx;
    logic                      r_pass2;
    logic                      r_first;
    logic signed [SCORE_W-1:0] r_max;
    logic signed [SCORE_W-1:0] r_min;
    logic [CIW-1:0]            r_best;
    logic                      r_exp_valid;
    logic [PROB_W-1:0]         r_exp;
    logic [SUMW-1:0]           r_sum;
    logic [PROB_W-1:0]         r_prob;
    logic [CIW-1:0]            r_prev;
    logic                      r_prev_valid;
    logic [PSW-1:0]            r_psum;
    logic [SCW-1:0]            r_scnt;
    logic                      r_sym_pend;
    logic                      r_seq;
    logic [MASK_AW-1:0]        r_clr_addr;
    logic                      r_clr_done;
    logic                      r_ovalid;
    logic                      r_okind;
    logic                      r_olast;
    logic [CLASS_OUT_W-1:0]    r_oclass;
    logic [CONF_W-1:0]         r_oconf;

    logic [SCORE_W-1:0]        w_row_q;
    logic                      w_mask_q;
    logic                      w_issue;
    logic                      w_row_we;
    logic                      w_mask_we;
    logic [MASK_AW-1:0]        w_mask_waddr;
    logic                      w_mask_wdata;
    logic                      w_allowed;
    logic signed [SCORE_W:0]   w_diff;
    logic [SCORE_W-4:0]        w_eidx;
    logic                      w_div_start;
    logic [DIV_DW-1:0]         w_dividend;
    logic [SUMW-1:0]           w_divisor;
    logic                      w_div_busy;
    logic [DIV_DW-1:0]         w_quo;
    logic                      w_out_free;

    // memory write and read control
    always_comb begin
        w_issue      = i_cmd.scan && (r_idx != r_cc);
        w_row_we     = w_acc && (w_act == ACT_SCORE) && (32'(r_cc) < NUM_CLASSES);
        w_mask_we    = i_cmd.clearing || (w_acc && (w_act == ACT_MASK));
        w_mask_waddr = i_cmd.clearing ? r_clr_addr : w_maddr;
        w_mask_wdata = i_cmd.clearing ? 1'b0 : w_mbit;
    end

    ctcg_ram #(.W(SCORE_W), .D(NUM_CLASSES)) u_row (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_cc[CIW-1:0]),
        .i_wdata (w_score),
        .i_raddr (r_idx[CIW-1:0]),
        .o_rdata (w_row_q)
    );

    ctcg_ram #(.W(1), .D(MASK_DEPTH)) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_mask_we),
        .i_waddr (w_mask_waddr),
        .i_wdata (w_mask_wdata),
        .i_raddr (MASK_AW'(r_idx)),
        .o_rdata (w_mask_q)
    );

    // class filter and exp table index
    always_comb begin
        w_allowed = !r_mask_en || (r_rd_idx == '0) ||
                    ((32'(r_rd_idx) < 32'(r_mask_size)) &&
                     (32'(r_rd_idx) < MASK_DEPTH) && w_mask_q);
        w_diff    = {r_max[SCORE_W-1], r_max} - {w_row_q[SCORE_W-1], w_row_q};
        w_eidx    = w_diff[SCORE_W:4];
    end

    // divider operand select
    always_comb begin
        w_div_start = i_cmd.div_prob || i_cmd.div_mean;
        w_dividend  = i_cmd.div_prob ? (DIV_DW'(1) << 32) : DIV_DW'(r_psum);
        w_divisor   = i_cmd.div_prob ? r_sum : SUMW'(r_scnt);
    end

    ctcg_div #(.DW(DIV_DW), .VW(SUMW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_out_free = !r_ovalid || i_m_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_en   <= 1'b0;
            r_mask_size <= SIZE_W'(8192);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MASK_ENABLE: r_mask_en   <= i_cfg_wdata[0];
                REG_MASK_SIZE:   r_mask_size <= i_cfg_wdata;
                default:         r_mask_en   <= r_mask_en;
            endcase
        end
    end

    // mask clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MASK_AW'(MASK_DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // row fill, scan passes and per-step reductions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc        <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_exp_valid <= 1'b0;
            r_pass2     <= 1'b0;
            r_first     <= 1'b1;
            r_seq       <= 1'b0;
        end else begin
            r_rd_valid  <= w_issue;
            r_rd_idx    <= r_idx[CIW-1:0];
            r_exp_valid <= r_rd_valid && r_pass2;
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_row_we) begin
                r_cc <= r_cc + 1'b1;
            end
            if (w_acc && (w_act == ACT_SCORE) && i_s_tlast) begin
                r_idx   <= '0;
                r_pass2 <= 1'b0;
                r_first <= 1'b1;
                r_seq   <= i_s_tuser[1];
            end
            if (i_cmd.start2) begin
                r_idx   <= '0;
                r_pass2 <= 1'b1;
            end
            if (i_cmd.update) begin
                r_cc <= '0;
            end
            // pass one: masked max, min and first best index (signed compares)
            if (r_rd_valid && !r_pass2 && w_allowed) begin
                if (r_first || ($signed(w_row_q) > r_max)) begin
                    r_max  <= w_row_q;
                    r_best <= r_rd_idx;
                end
                if (r_first || ($signed(w_row_q) < r_min)) begin
                    r_min <= w_row_q;
                end
                r_first <= 1'b0;
            end
        end
    end

    // pass two: exp table lookup and sum
    always_ff @(posedge i_clk) begin
        if (r_rd_valid && r_pass2 && w_allowed && (32'(w_eidx) < EXP_DEPTH)) begin
            r_exp <= EXP_TAB[w_eidx[EXP_AW-1:0]];
        end else begin
            r_exp <= '0;
        end
        if (i_cmd.start2) begin
            r_sum <= '0;
        end else if (r_exp_valid) begin
            r_sum <= r_sum + SUMW'(r_exp);
        end
        if (i_cmd.bypass) begin
            r_prob <= r_max[SCORE_W-1] ? '0 : {r_max[10:0], 6'd0};
        end else if (i_cmd.take_prob) begin
            r_prob <= w_quo[PROB_W-1:0];
        end
    end

    // sequence state: symbol collapse and probability mean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_psum       <= '0;
            r_scnt       <= '0;
            r_sym_pend   <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_sym_pend   <= (r_best != '0) && (!r_prev_valid || (r_best != r_prev));
                r_prev       <= r_best;
                r_prev_valid <= 1'b1;
                if (32'(r_scnt) < MAX_STEPS) begin
                    r_psum <= r_psum + PSW'(r_prob);
                    r_scnt <= r_scnt + 1'b1;
                end
            end
            if (i_cmd.load_sym) begin
                r_sym_pend <= 1'b0;
            end
            if (i_cmd.load_mean) begin
                r_prev_valid <= 1'b0;
                r_psum       <= '0;
                r_scnt       <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_sym) begin
            r_ovalid <= 1'b1;
            r_okind  <= KIND_SYMBOL;
            r_oclass <= CLASS_OUT_W'(r_best);
            r_oconf  <= '0;
            r_olast  <= 1'b0;
        end else if (i_cmd.load_mean) begin
            r_ovalid <= 1'b1;
            r_okind  <= KIND_MEAN;
            r_oclass <= '0;
            r_oconf  <= (w_quo > DIV_DW'(65535)) ? 16'hFFFF : w_quo[CONF_W-1:0];
            r_olast  <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {3'd0, r_oconf, r_oclass};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    // status
    always_comb begin
        o_sts.clear_done = r_clr_done;
        o_sts.step_acc   = w_acc && (w_act == ACT_SCORE) && i_s_tlast;
        o_sts.scan_end   = (r_idx == r_cc);
        o_sts.pipe_empty = !r_rd_valid && !r_exp_valid;
        o_sts.bypass_ok  = (r_min >= PROB_LOWER) && (r_max <= PROB_UPPER);
        o_sts.div_busy   = w_div_busy;
        o_sts.sym_pend   = r_sym_pend;
        o_sts.seq_end    = r_seq;
        o_sts.out_free   = w_out_free;
    end

endmodule

// ===== sv/ctc_greedy_decoder_masked.sv =====
// top level of the masked ctc greedy decoder
//
// channel  dir  handshake          payload
// s_axis   in   tvalid / tready    tdata score,mask_addr,mask_bit; tuser action,last_of_sequence
//                                  tlast last_of_step
// m_axis   out  tvalid / tready    tdata class_index,confidence; tuser kind; tlast last
// cfg      in   we (no wait)       addr register index, wdata value
//
// a score or mask write is taken while idle; a step's last score adds a first scan of the
// row memory and, unless the scores all lie in the narrow band, a second scan with exp
// lookup and a divide; then the step is updated and its symbol emitted, plus a divide
// for the mean at sequence end.
// the row and mask memories' single read ports set these scans.
// after reset the mask memory is swept to zero, address by address, before input is taken.
// a result waiting on m_axis stalls the next step only at its own emit point.
module ctc_greedy_decoder_masked
    import ctcg_pkg::*;
#(
    parameter int NUM_CLASSES = 8192,
    parameter int MAX_STEPS   = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [13:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // score[15:0], mask_addr[28:16], mask_bit[29]
    input  logic [1:0]  s_axis_tuser,   // action[0], last_of_sequence[1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // class_index[12:0], confidence[28:13]
    output logic        m_axis_tuser,   // kind[0]
    output logic        m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    ctcg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ctcg_dp #(.NUM_CLASSES(NUM_CLASSES), .MAX_STEPS(MAX_STEPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

    assign s_axis_tready = w_cmd.in_ready;

`ifndef ASSERT_OFF
    // a mean transaction always closes the sequence
    a_mean_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("mean result without last");

    // a symbol transaction is never the blank class
    a_sym_nonblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[12:0] != 13'd0))
        else $error("blank symbol emitted");

    // a symbol transaction carries no confidence
    a_sym_noconf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[28:13] == 16'd0))
        else $error("symbol with confidence");
`endif

endmodule
